/* rtl/string_literal_unescape_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef STRING_LITERAL_UNESCAPE_TOP_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SLU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/slu_pkg.sv */
// ----------------------------------------------------------------------------
// slu_pkg
// Types, character codes and digit decoders for the string literal unescaper.
// ----------------------------------------------------------------------------
package slu_pkg;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_BSLASH = 2'd1,
        MODE_HEX    = 2'd2,
        MODE_OCT    = 2'd3
    } esc_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       token_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       is_last;
    } out_item_t;

    localparam int unsigned MaxBeats = 3;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned AccW     = 12;

    // Bytes caused by one character, queued between front and back.
    typedef struct packed {
        logic [MaxBeats-1:0][ByteW-1:0] bytes;
        logic [1:0]                     count;  // 1..3
        logic                           term;   // final byte is the terminator
    } bundle_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [4:0] oct_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h37)
            r = {2'b10, 3'(c - 8'h30)};
        return r;
    endfunction

endpackage

/* rtl/slu_front.sv */
// ----------------------------------------------------------------------------
// slu_front
// Decodes one character per cycle unless q_full; emits its bytes as a bundle.
// ----------------------------------------------------------------------------
module slu_front import slu_pkg::*; #(
    parameter int unsigned MAX_ESCAPE_DIGITS = 3
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output bundle_t  q_data
);

    localparam int unsigned CntW = $clog2(MAX_ESCAPE_DIGITS + 1);

    logic            first_reg, first_next;
    logic            inq_reg, inq_next;
    esc_mode_t       mode_reg, mode_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [AccW-1:0] acc_reg, acc_next;

    logic            accept;
    logic [7:0]      c;
    logic            num_mode, plain_path, esc_path;
    logic [4:0]      dig;
    logic [AccW-1:0] grow;
    logic [CntW-1:0] cnt_inc;
    logic            num_full, dig_ok, esc_opens_num;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.char_in;

    // Character classification against the current escape state
    always_comb begin
        num_mode      = !first_reg && (mode_reg == MODE_HEX || mode_reg == MODE_OCT);
        dig           = (mode_reg == MODE_HEX) ? hex_digit(c) : oct_digit(c);
        dig_ok        = dig[4];
        grow          = (mode_reg == MODE_HEX) ? {acc_reg[AccW-5:0], dig[3:0]}
                                               : {acc_reg[AccW-4:0], dig[2:0]};
        cnt_inc       = cnt_reg + 1'b1;
        num_full      = cnt_inc >= CntW'(MAX_ESCAPE_DIGITS);
        esc_path      = !first_reg && mode_reg == MODE_BSLASH;
        plain_path    = !first_reg && (mode_reg == MODE_NONE || (num_mode && !dig_ok));
        esc_opens_num = esc_path && (c == CH_X_LO || c == CH_X_UP || c == CH_ZERO);
    end

    // Next state
    always_comb begin
        first_next = 1'b0;
        inq_next   = inq_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        if (num_mode && dig_ok) begin
            acc_next = grow;
            cnt_next = num_full ? '0 : cnt_inc;
            if (num_full)
                mode_next = MODE_NONE;
        end
        if (num_mode && !dig_ok) begin
            mode_next = MODE_NONE;
            cnt_next  = '0;
        end
        if (plain_path) begin
            if (c == CH_QUOTE)
                inq_next = !inq_reg;
            else if (inq_reg && c == CH_BSLASH)
                mode_next = MODE_BSLASH;
        end
        if (esc_path) begin
            unique case (c)
                CH_X_LO, CH_X_UP: begin
                    mode_next = MODE_HEX;
                    cnt_next  = '0;
                    acc_next  = '0;
                end
                CH_ZERO: begin
                    mode_next = MODE_OCT;
                    cnt_next  = '0;
                    acc_next  = '0;
                end
                default: mode_next = MODE_NONE;
            endcase
        end
        if (s_data.token_end) begin
            first_next = 1'b1;
            inq_next   = 1'b1;
            mode_next  = MODE_NONE;
            cnt_next   = '0;
            acc_next   = '0;
        end
    end

    // Emitted bytes
    always_comb begin
        logic [1:0] n;
        n       = 2'd0;
        q_data  = '0;
        if (num_mode && dig_ok && num_full) begin
            q_data.bytes[n] = grow[7:0];
            n = n + 1'b1;
        end
        if (num_mode && !dig_ok) begin
            q_data.bytes[n] = acc_reg[7:0];
            n = n + 1'b1;
        end
        if (plain_path && inq_reg && c != CH_QUOTE && c != CH_BSLASH) begin
            q_data.bytes[n] = c;
            n = n + 1'b1;
        end
        if (esc_path && !esc_opens_num) begin
            unique case (c)
                CH_BSLASH: q_data.bytes[n] = CH_BSLASH;
                CH_N:      q_data.bytes[n] = CH_LF;
                CH_R:      q_data.bytes[n] = CH_CR;
                CH_T:      q_data.bytes[n] = CH_TAB;
                CH_B:      q_data.bytes[n] = CH_BS;
                default:   q_data.bytes[n] = c;
            endcase
            n = n + 1'b1;
        end
        if (s_data.token_end) begin
            // number still open or just opened at the end of the token is flushed
            if (num_mode && dig_ok && !num_full) begin
                q_data.bytes[n] = grow[7:0];
                n = n + 1'b1;
            end else if (esc_opens_num) begin
                q_data.bytes[n] = 8'h00;
                n = n + 1'b1;
            end
            q_data.bytes[n] = 8'h00;
            n = n + 1'b1;
            q_data.term = 1'b1;
        end
        q_data.count = n;
        q_push       = accept && n != 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            inq_reg   <= 1'b1;
            mode_reg  <= MODE_NONE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
        end else if (accept) begin
            first_reg <= first_next;
            inq_reg   <= inq_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

/* rtl/slu_fifo.sv */
// ----------------------------------------------------------------------------
// slu_fifo
// Short register queue of byte bundles between the decoder and the emitter.
// ----------------------------------------------------------------------------
module slu_fifo import slu_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full       = cnt_reg == CW'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_data  = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? ((wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

/* rtl/slu_back.sv */
// ----------------------------------------------------------------------------
// slu_back
// Unpacks queued bundles into one registered beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module slu_back import slu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  bundle_t   head_data,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    logic [1:0] idx_reg, idx_next;
    logic       take, at_tail;

    always_comb begin
        take         = head_valid && (!m_valid_reg || m_ready);
        at_tail      = idx_reg == head_data.count - 2'd1;
        pop          = take && at_tail;
        idx_next     = take ? (at_tail ? 2'd0 : idx_reg + 2'd1) : idx_reg;
        m_valid_next = take ? 1'b1 : (m_valid_reg && !m_ready);
        m_data_next.byte_out = head_data.bytes[idx_reg];
        m_data_next.is_last  = head_data.term && at_tail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take)
            m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/string_literal_unescape_top.sv */
// ----------------------------------------------------------------------------
// string_literal_unescape_top
// C string literal escape decoder: quoted token characters in, bytes out.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the queue has room. The decoder
// classifies each character combinationally and queues the 1 to 3 bytes it
// causes, if any, as one entry of a FIFO_DEPTH-entry queue; the emitter
// sends one byte per cycle from a registered output while m_ready is high.
// Sustained rate is one character per cycle while the output is not stalled
// and each character yields at most one byte; the input stalls only once
// the queue fills. Bytes pass through the queue register, then the output
// register. The zero terminator carries is_last; the decoder is back in its
// reset state for the next token right after a token's final character.
module string_literal_unescape_top import slu_pkg::*; #(
    parameter int unsigned MAX_ESCAPE_DIGITS = 3,
    parameter int unsigned FIFO_DEPTH        = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic    q_full, q_push, q_pop, q_head_valid;
    bundle_t q_in, q_head;

    slu_front #(
        .MAX_ESCAPE_DIGITS(MAX_ESCAPE_DIGITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    slu_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    slu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* rtl/slu_checker.sv */
// ----------------------------------------------------------------------------
// slu_checker
// Port-level checks for the string literal unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_literal_unescape_top_macros.svh"

module slu_checker import slu_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled beat holds
    `SLU_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "output beat changed while stalled")

    // terminator is always a zero byte
    `SLU_ASSERT_NOW(a_term_zero, aclk, aresetn, m_valid && m_data.is_last, m_data.byte_out == 8'h00, "terminator is not zero")

    // queue is empty right out of reset
    `SLU_ASSERT_NOW(a_rst_ready, aclk, aresetn, !$past(aresetn), s_ready && !m_valid, "not idle after reset")

    // final character: output becomes valid via the queue, then the output register
    `SLU_ASSERT_NEXT(a_end_out, aclk, aresetn, s_valid && s_ready && s_data.token_end, ##1 m_valid, "no output after token end")

endmodule

bind string_literal_unescape_top slu_checker u_slu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
